@@ design/hsv_to_rgb_converter_macros.svh @@
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_macros.svh
// Assertion macros shared by the HSV to RGB converter.
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define H2R_ASSERT_NOW(label, ant, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error(msg);

// Consequent must hold a fixed number of cycles after the antecedent.
`define H2R_ASSERT_AFTER(label, ant, n, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> ##n (cons)) \
        else $error(msg);

`endif

@@ design/h2r_pkg.sv @@
// ----------------------------------------------------------------------------
// h2r_pkg
// Shared constants and widths for the HSV to RGB converter.
// ----------------------------------------------------------------------------
package h2r_pkg;

    // Ranges of the clamped inputs
    localparam int unsigned HUE_MAX    = 6400;  // 400 degrees in 1/16 degree
    localparam int unsigned HUE_FULL   = 5760;  // 360 degrees
    localparam int unsigned HUE_SECTOR = 960;   // 60 degrees
    localparam int unsigned UNIT_Q12   = 4096;  // 1.0 in Q4.12

    // Channel numerators are v * X over 4096*4096*960; X = 1.0 is this
    localparam int unsigned ONE_X = UNIT_Q12 * HUE_SECTOR;

    // Widths
    localparam int unsigned IN_W   = 16;
    localparam int unsigned HUE_W  = 13;   // 0..6400
    localparam int unsigned FRAC_W = 13;   // 0..4096
    localparam int unsigned REM_W  = 10;   // 0..959
    localparam int unsigned SEC_W  = 3;    // 0..6
    localparam int unsigned X_W    = 22;   // 0..ONE_X
    localparam int unsigned PROD_W = 34;   // v * X
    localparam int unsigned CHAN_W = 8;

    // Scale: 255 / (4096*4096*960) = 17 / 2^30
    localparam int unsigned SCALE_SHIFT = 30;

    // Sector codes
    localparam logic [SEC_W-1:0] SEC_0 = 3'd0;
    localparam logic [SEC_W-1:0] SEC_1 = 3'd1;
    localparam logic [SEC_W-1:0] SEC_2 = 3'd2;
    localparam logic [SEC_W-1:0] SEC_3 = 3'd3;
    localparam logic [SEC_W-1:0] SEC_4 = 3'd4;

endpackage

@@ design/hsv_to_rgb_converter.sv @@
// An accepted item raises the done strobe as it leaves the last datapath stage.
// Throughput: one item per cycle; busy is always low and never holds off start.
// Depth is set by the four-stage datapath: clamp and sector decode, channel
// factor multiply, value multiply, scale by 255.
// Reset (rst_n low, asynchronous) clears the valid pipeline; no done follows
// for items that were in flight.
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Pipelined HSV to 8-bit RGB conversion with input clamping.
// ----------------------------------------------------------------------------
`include "hsv_to_rgb_converter_macros.svh"

module hsv_to_rgb_converter
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic signed [h2r_pkg::IN_W-1:0] hue,
    input  logic signed [h2r_pkg::IN_W-1:0] saturation,
    input  logic signed [h2r_pkg::IN_W-1:0] value,
    output logic                            done,
    output logic [h2r_pkg::CHAN_W-1:0]      red,
    output logic [h2r_pkg::CHAN_W-1:0]      green,
    output logic [h2r_pkg::CHAN_W-1:0]      blue
);

    localparam int unsigned NSEC = 6;

    logic accept;

    // Stage 1 signals
    logic [h2r_pkg::HUE_W-1:0]  h_clamp;
    logic [h2r_pkg::HUE_W-1:0]  h_wrap;
    logic [h2r_pkg::FRAC_W-1:0] s_clamp;
    logic [h2r_pkg::FRAC_W-1:0] v_clamp;
    logic [h2r_pkg::SEC_W-1:0]  sec_next;
    logic [h2r_pkg::HUE_W-1:0]  base;
    logic [h2r_pkg::REM_W-1:0]  rem_next;

    logic                       vld1_reg;
    logic [h2r_pkg::SEC_W-1:0]  sec1_reg;
    logic [h2r_pkg::REM_W-1:0]  rem1_reg;
    logic [h2r_pkg::FRAC_W-1:0] s1_reg;
    logic [h2r_pkg::FRAC_W-1:0] v1_reg;

    // Stage 2 signals
    logic [h2r_pkg::X_W-1:0]    sp;
    logic [h2r_pkg::X_W-1:0]    sq;
    logic [h2r_pkg::X_W-1:0]    st;
    logic [h2r_pkg::REM_W-1:0]  rem_inv;

    logic                       vld2_reg;
    logic [h2r_pkg::SEC_W-1:0]  sec2_reg;
    logic [h2r_pkg::FRAC_W-1:0] v2_reg;
    logic [h2r_pkg::X_W-1:0]    xp_reg;
    logic [h2r_pkg::X_W-1:0]    xq_reg;
    logic [h2r_pkg::X_W-1:0]    xt_reg;

    // Stage 3/4 signals
    logic [h2r_pkg::X_W-1:0]    xv;
    logic [h2r_pkg::X_W-1:0]    xr;
    logic [h2r_pkg::X_W-1:0]    xg;
    logic [h2r_pkg::X_W-1:0]    xb;
    logic                       vld3_reg;
    logic                       vld4_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Clamp inputs: negative to zero, above range to the bound
    always_comb
    begin
        if (hue[h2r_pkg::IN_W-1])
            h_clamp = '0;
        else if (hue[h2r_pkg::IN_W-2:0] > (h2r_pkg::IN_W-1)'(h2r_pkg::HUE_MAX))
            h_clamp = h2r_pkg::HUE_W'(h2r_pkg::HUE_MAX);
        else
            h_clamp = hue[h2r_pkg::HUE_W-1:0];

        if (saturation[h2r_pkg::IN_W-1])
            s_clamp = '0;
        else if (saturation[h2r_pkg::IN_W-2:0] > (h2r_pkg::IN_W-1)'(h2r_pkg::UNIT_Q12))
            s_clamp = h2r_pkg::FRAC_W'(h2r_pkg::UNIT_Q12);
        else
            s_clamp = saturation[h2r_pkg::FRAC_W-1:0];

        if (value[h2r_pkg::IN_W-1])
            v_clamp = '0;
        else if (value[h2r_pkg::IN_W-2:0] > (h2r_pkg::IN_W-1)'(h2r_pkg::UNIT_Q12))
            v_clamp = h2r_pkg::FRAC_W'(h2r_pkg::UNIT_Q12);
        else
            v_clamp = value[h2r_pkg::FRAC_W-1:0];
    end

    // Sector decode: 360 degrees folds to 0, sector counts boundaries passed
    always_comb
    begin
        h_wrap = (h_clamp == h2r_pkg::HUE_W'(h2r_pkg::HUE_FULL)) ? '0 : h_clamp;
        sec_next = '0;
        for (int k = 1; k <= NSEC; k++)
        begin
            if (h_wrap >= h2r_pkg::HUE_W'(k * h2r_pkg::HUE_SECTOR))
                sec_next = sec_next + h2r_pkg::SEC_W'(1);
        end
        base     = h2r_pkg::HUE_W'(sec_next) * h2r_pkg::HUE_W'(h2r_pkg::HUE_SECTOR);
        rem_next = h2r_pkg::REM_W'(h_wrap - base);
    end

    // Channel factors: X = 1.0 - s*k with k = 960, rem or 960-rem
    assign rem_inv = h2r_pkg::REM_W'(h2r_pkg::HUE_SECTOR) - rem1_reg;
    assign sp = h2r_pkg::X_W'(s1_reg) * h2r_pkg::X_W'(h2r_pkg::HUE_SECTOR);
    assign sq = h2r_pkg::X_W'(s1_reg) * h2r_pkg::X_W'(rem1_reg);
    assign st = h2r_pkg::X_W'(s1_reg) * h2r_pkg::X_W'(rem_inv);

    // Datapath registers, no reset
    always_ff @(posedge clk)
    begin
        sec1_reg <= sec_next;
        rem1_reg <= rem_next;
        s1_reg   <= s_clamp;
        v1_reg   <= v_clamp;

        sec2_reg <= sec1_reg;
        v2_reg   <= v1_reg;
        xp_reg   <= h2r_pkg::X_W'(h2r_pkg::ONE_X) - sp;
        xq_reg   <= h2r_pkg::X_W'(h2r_pkg::ONE_X) - sq;
        xt_reg   <= h2r_pkg::X_W'(h2r_pkg::ONE_X) - st;
    end

    // Valid bits travel with the item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= accept;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
            vld4_reg <= vld3_reg;
        end
    end

    // Per-sector channel routing; sectors 5 and 6 share the last case
    assign xv = h2r_pkg::X_W'(h2r_pkg::ONE_X);

    always_comb
    begin
        case (sec2_reg)
            h2r_pkg::SEC_0:
            begin
                xr = xv;     xg = xt_reg; xb = xp_reg;
            end
            h2r_pkg::SEC_1:
            begin
                xr = xq_reg; xg = xv;     xb = xp_reg;
            end
            h2r_pkg::SEC_2:
            begin
                xr = xp_reg; xg = xv;     xb = xt_reg;
            end
            h2r_pkg::SEC_3:
            begin
                xr = xp_reg; xg = xq_reg; xb = xv;
            end
            h2r_pkg::SEC_4:
            begin
                xr = xt_reg; xg = xp_reg; xb = xv;
            end
            default:
            begin
                xr = xv;     xg = xp_reg; xb = xq_reg;
            end
        endcase
    end

    // Value multiply and byte scaling per channel
    h2r_chan_scale u_red
    (
        .clk    (clk),
        .val    (v2_reg),
        .factor (xr),
        .chan   (red)
    );

    h2r_chan_scale u_green
    (
        .clk    (clk),
        .val    (v2_reg),
        .factor (xg),
        .chan   (green)
    );

    h2r_chan_scale u_blue
    (
        .clk    (clk),
        .val    (v2_reg),
        .factor (xb),
        .chan   (blue)
    );

    assign done = vld4_reg;

    // Checks
    `H2R_ASSERT_AFTER(a_item_done, accept, 4, done, "accepted item did not complete in 4 cycles")
    `H2R_ASSERT_NOW(a_done_has_item, done, $past(accept, 4), "done without a matching item")
    `H2R_ASSERT_AFTER(a_grey, accept && (saturation[15] || saturation == 16'sd0), 4, red == green && green == blue, "zero saturation must give grey")
    `H2R_ASSERT_AFTER(a_black, accept && (value[15] || value == 16'sd0), 4, red == 8'd0 && green == 8'd0 && blue == 8'd0, "zero value must give black")

endmodule

@@ design/h2r_chan_scale.sv @@
// ----------------------------------------------------------------------------
// h2r_chan_scale
// One color channel: multiplies value by the channel factor, then scales by
// 255 and truncates to a byte. Two register stages.
// ----------------------------------------------------------------------------
module h2r_chan_scale
(
    input  logic                            clk,
    input  logic [h2r_pkg::FRAC_W-1:0]      val,
    input  logic [h2r_pkg::X_W-1:0]         factor,
    output logic [h2r_pkg::CHAN_W-1:0]      chan
);

    localparam int unsigned SUM_W = h2r_pkg::PROD_W + 5;

    logic [h2r_pkg::PROD_W-1:0] prod_reg;
    logic [h2r_pkg::PROD_W-1:0] prod_next;
    logic [SUM_W-1:0]           times17;
    logic [h2r_pkg::CHAN_W-1:0] chan_reg;
    logic [h2r_pkg::CHAN_W-1:0] chan_next;

    // Stage A: v * X
    assign prod_next = h2r_pkg::PROD_W'(val) * h2r_pkg::PROD_W'(factor);

    // Stage B: times 17 by shift and add, then drop 30 fraction bits
    assign times17   = SUM_W'({prod_reg, 4'b0000}) + SUM_W'(prod_reg);
    assign chan_next = times17[h2r_pkg::SCALE_SHIFT +: h2r_pkg::CHAN_W];

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        chan_reg <= chan_next;
    end

    assign chan = chan_reg;

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for hsv_to_rgb_converter. Pixels go in through the
// start/busy handshake from a queue. Each accepted pixel is converted by a
// fixed-point model kept here. Every done strobe is checked against the
// oldest pending conversion. The run has three phases of start gaps: light,
// heavy, then none.
// ----------------------------------------------------------------------------
module testbench;

    localparam int unsigned CHAN_SCALE = 255;
    // Common denominator of every channel numerator: 4096 * 4096 * 960
    localparam longint unsigned CHAN_DEN =
        64'(h2r_pkg::UNIT_Q12) * h2r_pkg::UNIT_Q12 * h2r_pkg::HUE_SECTOR;
    localparam int unsigned N_RANDOM   = 1625;
    localparam int unsigned MAX_REPORTS = 10;

    typedef struct {
        logic signed [h2r_pkg::IN_W-1:0] hue;
        logic signed [h2r_pkg::IN_W-1:0] sat;
        logic signed [h2r_pkg::IN_W-1:0] val;
    } hsv_pixel_t;

    typedef struct {
        logic [h2r_pkg::CHAN_W-1:0] red;
        logic [h2r_pkg::CHAN_W-1:0] green;
        logic [h2r_pkg::CHAN_W-1:0] blue;
    } rgb_pixel_t;

    typedef struct {
        hsv_pixel_t px;
        rgb_pixel_t rgb;
    } conversion_t;

    logic                              clk;
    logic                              rst_n;
    logic                              start;
    logic                              busy;
    logic signed [h2r_pkg::IN_W-1:0]   hue;
    logic signed [h2r_pkg::IN_W-1:0]   saturation;
    logic signed [h2r_pkg::IN_W-1:0]   value;
    logic                              done;
    logic [h2r_pkg::CHAN_W-1:0]        red;
    logic [h2r_pkg::CHAN_W-1:0]        green;
    logic [h2r_pkg::CHAN_W-1:0]        blue;

    hsv_pixel_t  pixel_queue[$];
    conversion_t rgb_pending[$];
    logic        took;
    int unsigned gap_pct;
    int unsigned n_pixels  = 0;
    int unsigned n_checked = 0;
    int unsigned n_grey    = 0;
    int unsigned n_errors  = 0;

    hsv_to_rgb_converter u_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .hue        (hue),
        .saturation (saturation),
        .value      (value),
        .done       (done),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

    // Clock, 12 ns period
    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Clamp a signed input to 0..hi
    function automatic longint unsigned clamp_field(logic signed [h2r_pkg::IN_W-1:0] x,
                                                    int unsigned hi);
        int xs;
        xs = x;
        if (xs < 0)
            return 0;
        if (xs > int'(hi))
            return hi;
        return xs;
    endfunction

    // Channel numerator over CHAN_DEN to an 8-bit byte, truncated
    function automatic logic [h2r_pkg::CHAN_W-1:0] chan_byte(longint unsigned num);
        longint unsigned q;
        q = (num * CHAN_SCALE) / CHAN_DEN;
        return q[h2r_pkg::CHAN_W-1:0];
    endfunction

    // Exact six-sector HSV to RGB conversion on integer numerators
    function automatic rgb_pixel_t hsv_to_rgb(hsv_pixel_t px);
        longint unsigned h, s, v, unit, nv, np, nq, nt, r, g, b, frac;
        logic [h2r_pkg::SEC_W-1:0] sec;
        rgb_pixel_t                res;
        h    = clamp_field(px.hue, h2r_pkg::HUE_MAX);
        s    = clamp_field(px.sat, h2r_pkg::UNIT_Q12);
        v    = clamp_field(px.val, h2r_pkg::UNIT_Q12);
        unit = 64'(h2r_pkg::UNIT_Q12) * h2r_pkg::HUE_SECTOR;
        nv   = v * unit;
        r    = nv;
        g    = nv;
        b    = nv;
        if (s != 0)
        begin
            // 360 degrees wraps to 0
            if (h == h2r_pkg::HUE_FULL)
                h = 0;
            sec  = h2r_pkg::SEC_W'(h / h2r_pkg::HUE_SECTOR);
            frac = h % h2r_pkg::HUE_SECTOR;
            np   = v * ((h2r_pkg::UNIT_Q12 - s) * h2r_pkg::HUE_SECTOR);
            nq   = v * (unit - s * frac);
            nt   = v * (unit - s * (h2r_pkg::HUE_SECTOR - frac));
            case (sec)
                h2r_pkg::SEC_0: begin r = nv; g = nt; b = np; end
                h2r_pkg::SEC_1: begin r = nq; g = nv; b = np; end
                h2r_pkg::SEC_2: begin r = np; g = nv; b = nt; end
                h2r_pkg::SEC_3: begin r = np; g = nq; b = nv; end
                h2r_pkg::SEC_4: begin r = nt; g = np; b = nv; end
                default:        begin r = nv; g = np; b = nq; end
            endcase
        end
        res.red   = chan_byte(r);
        res.green = chan_byte(g);
        res.blue  = chan_byte(b);
        return res;
    endfunction

    // Random field: mostly in range, with edges and raw 16-bit noise
    function automatic logic signed [h2r_pkg::IN_W-1:0] pick_field(int unsigned hi);
        case ($urandom_range(9))
            0:       return h2r_pkg::IN_W'($urandom);
            1:       return h2r_pkg::IN_W'(hi);
            2:       return '0;
            default: return h2r_pkg::IN_W'($urandom_range(hi));
        endcase
    endfunction

    function automatic hsv_pixel_t random_pixel();
        hsv_pixel_t px;
        px.hue = pick_field(h2r_pkg::HUE_MAX);
        // Sector boundaries, including the 360 degree wrap, now and then
        if ($urandom_range(7) == 0)
            px.hue = h2r_pkg::IN_W'(h2r_pkg::HUE_SECTOR * $urandom_range(6)
                                    + $urandom_range(1));
        px.sat = pick_field(h2r_pkg::UNIT_Q12);
        px.val = pick_field(h2r_pkg::UNIT_Q12);
        return px;
    endfunction

    function automatic hsv_pixel_t mk_pixel(int h, int s, int v);
        hsv_pixel_t px;
        px.hue = h2r_pkg::IN_W'(h);
        px.sat = h2r_pkg::IN_W'(s);
        px.val = h2r_pkg::IN_W'(v);
        return px;
    endfunction

    // Driver: present the next pixel once the current one is taken
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            start      <= 1'b0;
            hue        <= '0;
            saturation <= '0;
            value      <= '0;
        end
        else if (!start || took)
        begin
            if (pixel_queue.size() != 0 && $urandom_range(99) >= gap_pct)
            begin
                hsv_pixel_t px;
                px = pixel_queue.pop_front();
                start      <= 1'b1;
                hue        <= px.hue;
                saturation <= px.sat;
                value      <= px.val;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: record accepted pixels, check every done strobe
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            took <= 1'b0;
        end
        else
        begin
            conversion_t cv;
            took <= start && !busy;
            if (start && !busy)
            begin
                cv.px.hue = hue;
                cv.px.sat = saturation;
                cv.px.val = value;
                cv.rgb    = hsv_to_rgb(cv.px);
                rgb_pending.push_back(cv);
                n_pixels++;
                if (clamp_field(saturation, h2r_pkg::UNIT_Q12) == 0)
                    n_grey++;
            end
            if (done)
            begin
                if (rgb_pending.size() == 0)
                begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("[%0t] ERROR: rgb %0d/%0d/%0d with no pixel pending",
                                 $realtime, red, green, blue);
                end
                else
                begin
                    cv = rgb_pending.pop_front();
                    n_checked++;
                    if (red !== cv.rgb.red || green !== cv.rgb.green ||
                        blue !== cv.rgb.blue)
                    begin
                        n_errors++;
                        if (n_errors <= MAX_REPORTS)
                            $display("[%0t] ERROR: hsv %0d/%0d/%0d exp %0d/%0d/%0d got %0d/%0d/%0d",
                                     $realtime, cv.px.hue, cv.px.sat, cv.px.val,
                                     cv.rgb.red, cv.rgb.green, cv.rgb.blue,
                                     red, green, blue);
                    end
                end
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        rst_n      <= 1'b0;
        gap_pct    = 25;

        // Directed: sector edges, the 360 wrap, clamps and grey
        pixel_queue.push_back(mk_pixel(0, 4096, 4096));
        pixel_queue.push_back(mk_pixel(959, 4096, 4096));
        pixel_queue.push_back(mk_pixel(960, 4096, 4096));
        pixel_queue.push_back(mk_pixel(1920, 4096, 4096));
        pixel_queue.push_back(mk_pixel(2880, 2048, 4096));
        pixel_queue.push_back(mk_pixel(3840, 4096, 3000));
        pixel_queue.push_back(mk_pixel(4800, 1234, 4096));
        pixel_queue.push_back(mk_pixel(5759, 4096, 4096));
        pixel_queue.push_back(mk_pixel(5760, 4096, 4096));
        pixel_queue.push_back(mk_pixel(5761, 4096, 4096));
        pixel_queue.push_back(mk_pixel(6399, 4096, 4096));
        pixel_queue.push_back(mk_pixel(6400, 3000, 4096));
        pixel_queue.push_back(mk_pixel(6401, 4096, 2500));
        pixel_queue.push_back(mk_pixel(32767, 4096, 4096));
        pixel_queue.push_back(mk_pixel(-1, 4096, 4096));
        pixel_queue.push_back(mk_pixel(-32768, 2000, 4096));
        pixel_queue.push_back(mk_pixel(1000, 0, 2048));
        pixel_queue.push_back(mk_pixel(5760, 0, 4096));
        pixel_queue.push_back(mk_pixel(2000, -32768, 4096));
        pixel_queue.push_back(mk_pixel(2000, 4097, 4096));
        pixel_queue.push_back(mk_pixel(3000, 32767, 32767));
        pixel_queue.push_back(mk_pixel(3000, 4096, -1));
        pixel_queue.push_back(mk_pixel(4000, 4096, -32768));
        pixel_queue.push_back(mk_pixel(500, 4096, 0));
        pixel_queue.push_back(mk_pixel(1500, 1, 1));

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Three gap profiles on start: light, heavy, none
        for (int ph = 0; ph < 3; ph++)
        begin
            gap_pct = (ph == 0) ? 25 : (ph == 1) ? 81 : 0;
            for (int i = 0; i < N_RANDOM / 3; i++)
                pixel_queue.push_back(random_pixel());
            while (pixel_queue.size() != 0 || start)
                @(posedge clk);
        end

        while (rgb_pending.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Converted %0d pixels (%0d grey), %0d results checked, %0d errors.",
                 n_pixels, n_grey, n_checked, n_errors);
        $display("Covered all six sectors, the 360 wrap and input clamping under three gap profiles.");
        if (n_errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2ms;
        $display("Timeout: %0d results still pending", rgb_pending.size());
        $display("Verification failed");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+design
design/h2r_pkg.sv
design/h2r_chan_scale.sv
design/hsv_to_rgb_converter.sv
test/testbench.sv
